// ===== rtl/wsh_pkg.sv =====
// shared constants and tables of the highpass tap generator
package wsh_pkg;

    localparam int MAX_TAPS   = 256;
    localparam int NT_W       = 9;
    localparam int FC_W       = 17;
    localparam int FS_W       = 18;
    localparam int IDX_W      = 8;
    localparam int COEF_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_W      = 18;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_TAPS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 2'd2;

    localparam logic [NT_W-1:0] RST_NUM_TAPS    = 9'd31;
    localparam logic [FC_W-1:0] RST_CUTOFF      = 17'd1000;
    localparam logic [FS_W-1:0] RST_SAMPLE_RATE = 18'd8000;

    localparam int TURN_BITS     = 24;
    localparam int CORDIC_STAGES = 16;
    localparam int XY_W          = 33;
    localparam int Z_W           = 26;

    localparam logic signed [XY_W-1:0] CORDIC_X0 = 33'sd652032874;
    localparam int PI_Q29 = 1686629713;
    localparam int WIN_A  = 450971566;
    localparam int WIN_C  = 85899346;

    // arctangent of 2^-i in 2^-24 turns
    function automatic logic signed [Z_W-1:0] atan_turns(input int idx);
        logic signed [Z_W-1:0] v;
        unique case (idx)
            0:       v = 26'sd2097152;
            1:       v = 26'sd1238021;
            2:       v = 26'sd654136;
            3:       v = 26'sd332050;
            4:       v = 26'sd166669;
            5:       v = 26'sd83416;
            6:       v = 26'sd41718;
            7:       v = 26'sd20860;
            8:       v = 26'sd10430;
            9:       v = 26'sd5215;
            10:      v = 26'sd2608;
            11:      v = 26'sd1304;
            12:      v = 26'sd652;
            13:      v = 26'sd326;
            14:      v = 26'sd163;
            15:      v = 26'sd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/wsh_div_cell.sv =====
// one restoring division step: shifts in a dividend bit and produces one quotient bit
module wsh_div_cell #(
    parameter int DW = 18,
    parameter int NW = 49,
    parameter int QW = 49
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [DW-1:0] i_div,
    input  logic [DW-1:0] i_rem,
    input  logic [NW-1:0] i_num,
    input  logic [QW-1:0] i_quo,
    output logic [DW-1:0] o_div,
    output logic [DW-1:0] o_rem,
    output logic [NW-1:0] o_num,
    output logic [QW-1:0] o_quo
);

    logic [DW:0]   w_trial;
    logic [DW:0]   w_diff;
    logic          w_ge;
    logic [DW-1:0] r_div;
    logic [DW-1:0] r_rem;
    logic [NW-1:0] r_num;
    logic [QW-1:0] r_quo;

    assign w_trial = {i_rem, i_num[NW-1]};
    assign w_diff  = w_trial - {1'b0, i_div};
    assign w_ge    = w_trial >= {1'b0, i_div};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= i_div;
            r_rem <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
            r_num <= i_num << 1;
            r_quo <= {i_quo[QW-2:0], w_ge};
        end
    end

    assign o_div = r_div;
    assign o_rem = r_rem;
    assign o_num = r_num;
    assign o_quo = r_quo;

endmodule

// ===== rtl/wsh_cordic_cell.sv =====
// one rotation step of the sine/cosine cordic
module wsh_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [wsh_pkg::XY_W-1:0]    i_x,
    input  logic signed [wsh_pkg::XY_W-1:0]    i_y,
    input  logic signed [wsh_pkg::Z_W-1:0]     i_z,
    input  logic [1:0]                         i_quad,
    output logic signed [wsh_pkg::XY_W-1:0]    o_x,
    output logic signed [wsh_pkg::XY_W-1:0]    o_y,
    output logic signed [wsh_pkg::Z_W-1:0]     o_z,
    output logic [1:0]                         o_quad
);

    localparam logic signed [wsh_pkg::Z_W-1:0] ATAN = wsh_pkg::atan_turns(STAGE);

    logic signed [wsh_pkg::XY_W-1:0] w_dx;
    logic signed [wsh_pkg::XY_W-1:0] w_dy;
    logic signed [wsh_pkg::XY_W-1:0] r_x;
    logic signed [wsh_pkg::XY_W-1:0] r_y;
    logic signed [wsh_pkg::Z_W-1:0]  r_z;
    logic [1:0]                      r_quad;

    assign w_dx = i_y >>> STAGE;
    assign w_dy = i_x >>> STAGE;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!i_z[wsh_pkg::Z_W-1]) begin
                r_x <= i_x - w_dx;
                r_y <= i_y + w_dy;
                r_z <= i_z - ATAN;
            end else begin
                r_x <= i_x + w_dx;
                r_y <= i_y - w_dy;
                r_z <= i_z + ATAN;
            end
            r_quad <= i_quad;
        end
    end

    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
    assign o_quad = r_quad;

endmodule

// ===== rtl/windowed_sinc_highpass_tap_gen_core.sv =====
// Blackman-windowed sinc highpass tap generator: one Q1.15 coefficient per requested tap index.
// Takes one tap index per clock unless the input is stalled and presents one coefficient
// per item, in order. The pipeline depth comes from the chain of 49 division cells that
// forms the sine and window angles (and the centre tap), the 16 cordic cells and the 29
// division cells that divide the sine by pi*m. A two-entry output buffer keeps the
// pipeline moving while a result waits; the input is stalled only when the last stage
// holds an item, both buffer entries are full and the output is stalled.
module windowed_sinc_highpass_tap_gen_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [wsh_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [wsh_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [wsh_pkg::IDX_W-1:0]          i_tap_index,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [wsh_pkg::COEF_W-1:0]  o_coefficient,
    output logic                               o_index_out_of_range,
    output logic [wsh_pkg::IDX_W-1:0]          o_tap_echo
);

    localparam int XW  = wsh_pkg::XY_W;
    localparam int ZW  = wsh_pkg::Z_W;
    localparam int ADW = wsh_pkg::FS_W;
    localparam int ANW = 49;
    localparam int ALEN = 49;
    localparam int WDW = 8;
    localparam int WQW = wsh_pkg::TURN_BITS;
    localparam int HDW = 39;
    localparam int HQW = 29;
    localparam int CLEN = wsh_pkg::CORDIC_STAGES;

    typedef struct packed {
        logic [1:0]           quad;
        logic signed [ZW-1:0] z;
    } t_ang;

    typedef struct packed {
        logic signed [XW-1:0] c;
        logic signed [XW-1:0] s;
    } t_cs;

    typedef struct packed {
        logic        oor;
        logic        mz;
        logic        one;
        logic [7:0]  n;
        logic [HDW-1:0] piam;
    } t_sba;

    typedef struct packed {
        logic        oor;
        logic        mz;
        logic        one;
        logic [7:0]  n;
        logic [HDW-1:0] piam;
        logic signed [47:0] hc;
    } t_sbc;

    typedef struct packed {
        logic        oor;
        logic        mz;
        logic [7:0]  n;
        logic        sn_neg;
        logic signed [47:0] hc;
        logic signed [18:0] ws;
    } t_sbh;

    typedef struct packed {
        logic signed [15:0] coef;
        logic               oor;
        logic [7:0]         n;
    } t_res;

    function automatic t_ang quad_reduce(input logic [23:0] t);
        t_ang        a;
        logic [23:0] s;
        logic [23:0] z;
        s      = t + 24'h200000;
        a.quad = s[23:22];
        z      = t - {a.quad, 22'b0};
        a.z    = ZW'($signed(z));
        return a;
    endfunction

    function automatic t_cs quad_map(input logic [1:0] q, input logic signed [XW-1:0] x,
                                     input logic signed [XW-1:0] y);
        t_cs r;
        unique case (q)
            2'd0: begin r.c = x;  r.s = y;  end
            2'd1: begin r.c = -y; r.s = x;  end
            2'd2: begin r.c = -x; r.s = -y; end
            2'd3: begin r.c = y;  r.s = -x; end
            default: begin r.c = x; r.s = y; end
        endcase
        return r;
    endfunction

    // configuration
    logic [wsh_pkg::NT_W-1:0] r_num_taps;
    logic [wsh_pkg::FC_W-1:0] r_cutoff_hz;
    logic [wsh_pkg::FS_W-1:0] r_sample_rate_hz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_taps       <= wsh_pkg::RST_NUM_TAPS;
            r_cutoff_hz      <= wsh_pkg::RST_CUTOFF;
            r_sample_rate_hz <= wsh_pkg::RST_SAMPLE_RATE;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                wsh_pkg::CFG_NUM_TAPS:    r_num_taps       <= i_cfg_data[8:0];
                wsh_pkg::CFG_CUTOFF:      r_cutoff_hz      <= i_cfg_data[16:0];
                wsh_pkg::CFG_SAMPLE_RATE: r_sample_rate_hz <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [8:0]        w_taps;
    logic [17:0]       w_fs;
    logic [7:0]        w_half;
    logic [7:0]        w_tm1;
    logic signed [8:0] w_m;
    logic [7:0]        w_am;
    logic              w_oor;

    assign w_taps = (r_num_taps > 9'(wsh_pkg::MAX_TAPS)) ? 9'(wsh_pkg::MAX_TAPS) : r_num_taps;
    assign w_fs   = (r_sample_rate_hz == '0) ? 18'd1 : r_sample_rate_hz;
    assign w_tm1  = 8'(w_taps - 9'd1);
    assign w_half = 8'((w_taps - 9'd1) >> 1);
    assign w_m    = $signed({1'b0, i_tap_index}) - $signed({1'b0, w_half});
    assign w_am   = w_m[8] ? 8'(-w_m) : w_m[7:0];
    assign w_oor  = {1'b0, i_tap_index} >= w_taps;

    // flow control
    logic w_en;
    logic w_pop;
    logic w_push;
    logic r_p5_v;
    logic r_o_v;
    logic r_t_v;

    assign w_pop      = r_o_v && !i_out_stall;
    assign w_en       = !r_p5_v || !r_t_v || w_pop;
    assign w_push     = w_en && r_p5_v;
    assign o_in_stall = !w_en;

    // stage 0: index decode
    logic       r_p0_v;
    logic [7:0] r_p0_n;
    logic       r_p0_oor;
    logic       r_p0_mz;
    logic       r_p0_one;
    logic [7:0] r_p0_am;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p0_n   <= i_tap_index;
            r_p0_oor <= w_oor;
            r_p0_mz  <= (w_m == '0);
            r_p0_one <= (w_taps == 9'd1);
            r_p0_am  <= w_am;
        end
    end

    // stage 1: products and dividends
    logic           r_p1_v;
    t_sba           r_p1_sb;
    logic [ANW-1:0] r_p1_numa;
    logic [ANW-1:0] r_p1_numw;
    logic [24:0]    w_fcam;
    logic [HDW-1:0] w_piam;

    assign w_fcam = 25'(r_cutoff_hz) * 25'(r_p0_am);
    assign w_piam = 39'(r_p0_am) * 39'(wsh_pkg::PI_Q29);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1_sb.oor  <= r_p0_oor;
            r_p1_sb.mz   <= r_p0_mz;
            r_p1_sb.one  <= r_p0_one;
            r_p1_sb.n    <= r_p0_n;
            r_p1_sb.piam <= w_piam;
            r_p1_numa    <= r_p0_mz ? {1'b0, r_cutoff_hz, 31'b0} : {w_fcam, 24'b0};
            r_p1_numw    <= {17'b0, r_p0_n, 24'b0};
        end
    end

    // angle division chains
    logic [ADW-1:0] w_a_div [0:ALEN];
    logic [ADW-1:0] w_a_rem [0:ALEN];
    logic [ANW-1:0] w_a_num [0:ALEN];
    logic [ANW-1:0] w_a_quo [0:ALEN];
    logic [WDW-1:0] w_w_div [0:ALEN];
    logic [WDW-1:0] w_w_rem [0:ALEN];
    logic [ANW-1:0] w_w_num [0:ALEN];
    logic [WQW-1:0] w_w_quo [0:ALEN];

    assign w_a_div[0] = w_fs;
    assign w_a_rem[0] = '0;
    assign w_a_num[0] = r_p1_numa;
    assign w_a_quo[0] = '0;
    assign w_w_div[0] = w_tm1;
    assign w_w_rem[0] = '0;
    assign w_w_num[0] = r_p1_numw;
    assign w_w_quo[0] = '0;

    for (genvar k = 0; k < ALEN; k++) begin : g_adiv
        wsh_div_cell #(.DW(ADW), .NW(ANW), .QW(ANW)) u_acell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_div (w_a_div[k]),
            .i_rem (w_a_rem[k]),
            .i_num (w_a_num[k]),
            .i_quo (w_a_quo[k]),
            .o_div (w_a_div[k+1]),
            .o_rem (w_a_rem[k+1]),
            .o_num (w_a_num[k+1]),
            .o_quo (w_a_quo[k+1])
        );
        wsh_div_cell #(.DW(WDW), .NW(ANW), .QW(WQW)) u_wcell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_div (w_w_div[k]),
            .i_rem (w_w_rem[k]),
            .i_num (w_w_num[k]),
            .i_quo (w_w_quo[k]),
            .o_div (w_w_div[k+1]),
            .o_rem (w_w_rem[k+1]),
            .o_num (w_w_num[k+1]),
            .o_quo (w_w_quo[k+1])
        );
    end

    logic r_sa_v  [1:ALEN];
    t_sba r_sa_sb [1:ALEN];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sa_sb[1] <= r_p1_sb;
            for (int k = 2; k <= ALEN; k++) begin
                r_sa_sb[k] <= r_sa_sb[k-1];
            end
        end
    end

    // stage 2: quadrant reduction and centre tap
    logic               r_p2_v;
    t_sbc               r_p2_sb;
    t_ang               r_p2_ang [0:2];
    logic [23:0]        w_t1;
    logic signed [49:0] w_hc_full;
    logic signed [47:0] w_hc;

    assign w_t1      = w_w_quo[ALEN];
    assign w_hc_full = 50'sd1073741824 - $signed({1'b0, w_a_quo[ALEN]});
    assign w_hc      = (w_hc_full < -50'sd70368744177664) ? -48'sd70368744177664
                                                          : 48'(w_hc_full);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p2_sb.oor  <= r_sa_sb[ALEN].oor;
            r_p2_sb.mz   <= r_sa_sb[ALEN].mz;
            r_p2_sb.one  <= r_sa_sb[ALEN].one;
            r_p2_sb.n    <= r_sa_sb[ALEN].n;
            r_p2_sb.piam <= r_sa_sb[ALEN].piam;
            r_p2_sb.hc   <= w_hc;
            r_p2_ang[0]  <= quad_reduce(w_a_quo[ALEN][23:0]);
            r_p2_ang[1]  <= quad_reduce(w_t1);
            r_p2_ang[2]  <= quad_reduce({w_t1[22:0], 1'b0});
        end
    end

    // cordic chains: sine angle, first and second window angles
    logic signed [XW-1:0] w_cx [0:2][0:CLEN];
    logic signed [XW-1:0] w_cy [0:2][0:CLEN];
    logic signed [ZW-1:0] w_cz [0:2][0:CLEN];
    logic [1:0]           w_cq [0:2][0:CLEN];

    for (genvar g = 0; g < 3; g++) begin : g_cordic
        assign w_cx[g][0] = wsh_pkg::CORDIC_X0;
        assign w_cy[g][0] = '0;
        assign w_cz[g][0] = r_p2_ang[g].z;
        assign w_cq[g][0] = r_p2_ang[g].quad;
        for (genvar k = 0; k < CLEN; k++) begin : g_cell
            wsh_cordic_cell #(.STAGE(k)) u_cell (
                .i_clk  (i_clk),
                .i_en   (w_en),
                .i_x    (w_cx[g][k]),
                .i_y    (w_cy[g][k]),
                .i_z    (w_cz[g][k]),
                .i_quad (w_cq[g][k]),
                .o_x    (w_cx[g][k+1]),
                .o_y    (w_cy[g][k+1]),
                .o_z    (w_cz[g][k+1]),
                .o_quad (w_cq[g][k+1])
            );
        end
    end

    logic r_sc_v  [1:CLEN];
    t_sbc r_sc_sb [1:CLEN];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sc_sb[1] <= r_p2_sb;
            for (int k = 2; k <= CLEN; k++) begin
                r_sc_sb[k] <= r_sc_sb[k-1];
            end
        end
    end

    // stage 3: quadrant mapping and window product
    t_cs w_sin_cs;
    t_cs w_c1_cs;
    t_cs w_c2_cs;

    assign w_sin_cs = quad_map(w_cq[0][CLEN], w_cx[0][CLEN], w_cy[0][CLEN]);
    assign w_c1_cs  = quad_map(w_cq[1][CLEN], w_cx[1][CLEN], w_cy[1][CLEN]);
    assign w_c2_cs  = quad_map(w_cq[2][CLEN], w_cx[2][CLEN], w_cy[2][CLEN]);

    logic                 r_p3_v;
    t_sbc                 r_p3_sb;
    logic [XW-1:0]        r_p3_abs_sn;
    logic                 r_p3_sn_neg;
    logic signed [XW-1:0] r_p3_c1;
    logic signed [60:0]   r_p3_prodc;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p3_sb     <= r_sc_sb[CLEN];
            r_p3_sn_neg <= w_sin_cs.s[XW-1];
            r_p3_abs_sn <= w_sin_cs.s[XW-1] ? XW'(-w_sin_cs.s) : XW'(w_sin_cs.s);
            r_p3_c1     <= w_c1_cs.c;
            r_p3_prodc  <= w_c2_cs.c * 61'sd85899346;
        end
    end

    logic signed [33:0] w_win;
    logic signed [18:0] w_ws;
    t_sbh               w_sbh_in;

    assign w_win = 34'(wsh_pkg::WIN_A) - 34'(r_p3_c1 >>> 1) + 34'(r_p3_prodc >>> 30);
    assign w_ws  = r_p3_sb.one ? 19'sd32768 : 19'(w_win >>> 15);

    assign w_sbh_in.oor    = r_p3_sb.oor;
    assign w_sbh_in.mz     = r_p3_sb.mz;
    assign w_sbh_in.n      = r_p3_sb.n;
    assign w_sbh_in.sn_neg = r_p3_sn_neg;
    assign w_sbh_in.hc     = r_p3_sb.hc;
    assign w_sbh_in.ws     = w_ws;

    // sine over pi*|m| division chain
    logic [HDW-1:0] w_h_div [0:HQW];
    logic [HDW-1:0] w_h_rem [0:HQW];
    logic [0:0]     w_h_num [0:HQW];
    logic [HQW-1:0] w_h_quo [0:HQW];

    assign w_h_div[0] = r_p3_sb.piam;
    assign w_h_rem[0] = HDW'(r_p3_abs_sn);
    assign w_h_num[0] = 1'b0;
    assign w_h_quo[0] = '0;

    for (genvar k = 0; k < HQW; k++) begin : g_hdiv
        wsh_div_cell #(.DW(HDW), .NW(1), .QW(HQW)) u_hcell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_div (w_h_div[k]),
            .i_rem (w_h_rem[k]),
            .i_num (w_h_num[k]),
            .i_quo (w_h_quo[k]),
            .o_div (w_h_div[k+1]),
            .o_rem (w_h_rem[k+1]),
            .o_num (w_h_num[k+1]),
            .o_quo (w_h_quo[k+1])
        );
    end

    logic r_sh_v  [1:HQW];
    t_sbh r_sh_sb [1:HQW];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sh_sb[1] <= w_sbh_in;
            for (int k = 2; k <= HQW; k++) begin
                r_sh_sb[k] <= r_sh_sb[k-1];
            end
        end
    end

    // stage 4: ideal response
    logic               r_p4_v;
    logic signed [47:0] r_p4_h;
    logic signed [18:0] r_p4_ws;
    logic               r_p4_oor;
    logic [7:0]         r_p4_n;
    logic signed [47:0] w_hq;
    t_sbh               w_sbh_out;

    assign w_sbh_out = r_sh_sb[HQW];
    assign w_hq      = $signed({19'b0, w_h_quo[HQW]});

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p4_h   <= w_sbh_out.mz ? w_sbh_out.hc : (w_sbh_out.sn_neg ? w_hq : -w_hq);
            r_p4_ws  <= w_sbh_out.ws;
            r_p4_oor <= w_sbh_out.oor;
            r_p4_n   <= w_sbh_out.n;
        end
    end

    // stage 5: windowed product
    logic signed [66:0] r_p5_p;
    logic               r_p5_oor;
    logic [7:0]         r_p5_n;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p5_p   <= r_p4_h * r_p4_ws;
            r_p5_oor <= r_p4_oor;
            r_p5_n   <= r_p4_n;
        end
    end

    // rounding and saturation
    logic signed [66:0] w_rnd;
    logic signed [66:0] w_shr;
    t_res               w_res;

    assign w_rnd = r_p5_p + 67'sd536870912;
    assign w_shr = w_rnd >>> 30;

    always_comb begin
        w_res.oor = r_p5_oor;
        w_res.n   = r_p5_n;
        if (r_p5_oor) begin
            w_res.coef = '0;
        end else if (w_shr > 67'sd32767) begin
            w_res.coef = 16'sh7fff;
        end else if (w_shr < -67'sd32768) begin
            w_res.coef = -16'sh8000;
        end else begin
            w_res.coef = 16'(w_shr);
        end
    end

    // valid bits of every stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0_v <= 1'b0;
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
            r_p3_v <= 1'b0;
            r_p4_v <= 1'b0;
            r_p5_v <= 1'b0;
            for (int k = 1; k <= ALEN; k++) begin
                r_sa_v[k] <= 1'b0;
            end
            for (int k = 1; k <= CLEN; k++) begin
                r_sc_v[k] <= 1'b0;
            end
            for (int k = 1; k <= HQW; k++) begin
                r_sh_v[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_p0_v    <= i_in_valid;
            r_p1_v    <= r_p0_v;
            r_sa_v[1] <= r_p1_v;
            for (int k = 2; k <= ALEN; k++) begin
                r_sa_v[k] <= r_sa_v[k-1];
            end
            r_p2_v    <= r_sa_v[ALEN];
            r_sc_v[1] <= r_p2_v;
            for (int k = 2; k <= CLEN; k++) begin
                r_sc_v[k] <= r_sc_v[k-1];
            end
            r_p3_v    <= r_sc_v[CLEN];
            r_sh_v[1] <= r_p3_v;
            for (int k = 2; k <= HQW; k++) begin
                r_sh_v[k] <= r_sh_v[k-1];
            end
            r_p4_v    <= r_sh_v[HQW];
            r_p5_v    <= r_p4_v;
        end
    end

    // two-entry output buffer: head drives the ports, tail catches an item under stall
    t_res r_o_res;
    t_res r_t_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
            r_t_v <= 1'b0;
        end else if (w_pop) begin
            if (r_t_v) begin
                r_t_v <= w_push;
            end else begin
                r_o_v <= w_push;
            end
        end else if (!r_o_v) begin
            r_o_v <= w_push;
        end else if (w_push) begin
            r_t_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            if (r_t_v) begin
                r_o_res <= r_t_res;
                if (w_push) begin
                    r_t_res <= w_res;
                end
            end else if (w_push) begin
                r_o_res <= w_res;
            end
        end else if (!r_o_v) begin
            if (w_push) begin
                r_o_res <= w_res;
            end
        end else if (w_push) begin
            r_t_res <= w_res;
        end
    end

    assign o_out_valid          = r_o_v;
    assign o_coefficient        = r_o_res.coef;
    assign o_index_out_of_range = r_o_res.oor;
    assign o_tap_echo           = r_o_res.n;

endmodule

// ===== tb/sv/tb.sv =====
// self-checking testbench for the windowed sinc highpass tap generator
module tb;

    localparam logic [wsh_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        logic signed [wsh_pkg::COEF_W-1:0] coef;
        logic                              oor;
        logic [wsh_pkg::IDX_W-1:0]         echo;
    } t_tap_result;

    class t_tap_scoreboard;
        logic [wsh_pkg::NT_W-1:0] num_taps;
        logic [wsh_pkg::FC_W-1:0] cutoff;
        logic [wsh_pkg::FS_W-1:0] rate;
        t_tap_result     pending_taps[$];
        int              errors;
        longint          atan_tab[wsh_pkg::CORDIC_STAGES];

        function new();
            num_taps = wsh_pkg::RST_NUM_TAPS;
            cutoff   = wsh_pkg::RST_CUTOFF;
            rate     = wsh_pkg::RST_SAMPLE_RATE;
            errors   = 0;
            atan_tab = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
                         10430, 5215, 2608, 1304, 652, 326, 163, 81};
        endfunction

        function void write_reg(logic [wsh_pkg::CFG_IDX_W-1:0] idx,
                                logic [wsh_pkg::CFG_W-1:0] val);
            case (idx)
                wsh_pkg::CFG_NUM_TAPS:    num_taps = val[wsh_pkg::NT_W-1:0];
                wsh_pkg::CFG_CUTOFF:      cutoff   = val[wsh_pkg::FC_W-1:0];
                wsh_pkg::CFG_SAMPLE_RATE: rate     = val[wsh_pkg::FS_W-1:0];
                default: ;
            endcase
        endfunction

        // cosine and sine in Q30 of an angle in 2^-24 turns
        function void rotate(bit [31:0] t, output longint cs, output longint sn);
            bit [31:0] q;
            longint    z, x, y, dx, dy;
            q = ((t + 32'h0020_0000) >> 22) & 32'd3;
            z = longint'((t - (q << 22)) & 32'h00FF_FFFF);
            if (z >= (64'sd1 << 23)) z -= (64'sd1 << 24);
            x = 652032874;
            y = 0;
            for (int i = 0; i < wsh_pkg::CORDIC_STAGES; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx; y += dy; z -= atan_tab[i];
                end else begin
                    x += dx; y -= dy; z += atan_tab[i];
                end
            end
            case (q)
                0: begin cs = x;  sn = y;  end
                1: begin cs = -y; sn = x;  end
                2: begin cs = -x; sn = -y; end
                default: begin cs = y; sn = -x; end
            endcase
        endfunction

        function t_tap_result tap_value(logic [wsh_pkg::IDX_W-1:0] n);
            t_tap_result r;
            longint taps, fs, fc, m, am, rem, h, w, p, c, cs, sn, c1, c2;
            bit [31:0] t1, t2;
            taps = (num_taps > wsh_pkg::MAX_TAPS) ? wsh_pkg::MAX_TAPS : num_taps;
            fs   = (rate == 0) ? 1 : rate;
            fc   = cutoff;
            r.echo = n;
            r.oor  = 1'b1;
            r.coef = '0;
            if (n >= taps) return r;
            r.oor = 1'b0;
            m = longint'(n) - (taps - 1) / 2;
            if (m == 0) begin
                h = (64'sd1 << 30) - ((fc << 31) / fs);
            end else begin
                am  = (m < 0) ? -m : m;
                rem = (fc * am) % fs;
                t1  = 32'(((rem << 24) / fs) & 64'hFF_FFFF);
                rotate(t1, cs, sn);
                h = -((sn * (64'sd1 << 29)) / (longint'(wsh_pkg::PI_Q29) * am));
            end
            if (h > (64'sd1 << 46)) h = 64'sd1 << 46;
            if (h < -(64'sd1 << 46)) h = -(64'sd1 << 46);
            if (taps == 1) begin
                w = 64'sd1 << 30;
            end else begin
                t1 = 32'(((longint'(n) << 24) / (taps - 1)) & 64'hFF_FFFF);
                t2 = (t1 << 1) & 32'h00FF_FFFF;
                rotate(t1, c1, sn);
                rotate(t2, c2, sn);
                w = longint'(wsh_pkg::WIN_A) - ((c1 * 536870912) >>> 30)
                    + ((c2 * longint'(wsh_pkg::WIN_C)) >>> 30);
            end
            p = h * (w >>> 15);
            c = (p + (64'sd1 << 29)) >>> 30;
            if (c > 32767) c = 32767;
            if (c < -32768) c = -32768;
            r.coef = c[wsh_pkg::COEF_W-1:0];
            return r;
        endfunction

        function void note_request(logic [wsh_pkg::IDX_W-1:0] n);
            pending_taps.push_back(tap_value(n));
        endfunction

        function void check_result(logic signed [wsh_pkg::COEF_W-1:0] coef, logic oor,
                                   logic [wsh_pkg::IDX_W-1:0] echo);
            t_tap_result e;
            if (pending_taps.size() == 0) begin
                $display("%0t: unexpected result coef=%0d oor=%0b tap=%0d",
                         $time, coef, oor, echo);
                errors++;
                return;
            end
            e = pending_taps.pop_front();
            if (coef !== e.coef) begin
                $display("%0t: coefficient exp %0d got %0d (tap %0d)",
                         $time, e.coef, coef, e.echo);
                errors++;
            end
            if (oor !== e.oor) begin
                $display("%0t: out of range flag exp %0b got %0b (tap %0d)",
                         $time, e.oor, oor, e.echo);
                errors++;
            end
            if (echo !== e.echo) begin
                $display("%0t: tap echo exp %0d got %0d", $time, e.echo, echo);
                errors++;
            end
        endfunction
    endclass

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_cfg_wr_en = 1'b0;
    logic [wsh_pkg::CFG_IDX_W-1:0]     i_cfg_idx = '0;
    logic [wsh_pkg::CFG_W-1:0]         i_cfg_data = '0;
    logic                              i_in_valid = 1'b0;
    logic                              o_in_stall;
    logic [wsh_pkg::IDX_W-1:0]         i_tap_index = '0;
    logic                              o_out_valid;
    logic                              i_out_stall = 1'b0;
    logic signed [wsh_pkg::COEF_W-1:0] o_coefficient;
    logic                              o_index_out_of_range;
    logic [wsh_pkg::IDX_W-1:0]         o_tap_echo;

    windowed_sinc_highpass_tap_gen_core dut (.*);

    always #2 i_clk = ~i_clk;

    t_tap_scoreboard sb = new();
    bit no_gaps = 1'b0;
    bit hold_req = 1'b0;

    function automatic int draw_gap();
        return no_gaps ? 0 : $urandom_range(0, 16);
    endfunction

    // result side: random stalls, plus one long hold-off on request
    initial begin : sink
        int wait_cnt;
        int hold_cnt;
        wait_cnt = 0;
        hold_cnt = 0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) begin
                sb.check_result(o_coefficient, o_index_out_of_range, o_tap_echo);
                wait_cnt = draw_gap();
            end
            if (hold_req) begin
                hold_req = 1'b0;
                hold_cnt = 300;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_out_stall <= 1'b1;
            end else if (wait_cnt > 0) begin
                wait_cnt--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic send_tap(logic [wsh_pkg::IDX_W-1:0] n);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_tap_index <= n;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(n);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending_taps.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [wsh_pkg::CFG_IDX_W-1:0] idx,
                             logic [wsh_pkg::CFG_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
    endtask

    task automatic set_filter(int nt, int fc, int fs);
        write_reg(wsh_pkg::CFG_NUM_TAPS, wsh_pkg::CFG_W'(nt));
        write_reg(wsh_pkg::CFG_CUTOFF, wsh_pkg::CFG_W'(fc));
        write_reg(wsh_pkg::CFG_SAMPLE_RATE, wsh_pkg::CFG_W'(fs));
        write_reg(CFG_UNUSED, wsh_pkg::CFG_W'($urandom));
        i_cfg_wr_en <= 1'b0;
    endtask

    // mostly in-range indexes, some anywhere in the field
    task automatic random_taps(int count);
        int taps;
        taps = (sb.num_taps > wsh_pkg::MAX_TAPS) ? wsh_pkg::MAX_TAPS : sb.num_taps;
        repeat (count) begin
            if (taps > 0 && $urandom_range(0, 9) < 8)
                send_tap(wsh_pkg::IDX_W'($urandom_range(0, taps - 1)));
            else
                send_tap(wsh_pkg::IDX_W'($urandom_range(0, 255)));
        end
    endtask

    initial begin : timeout
        #4000000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : main
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: edges, centre tap, out of range
        send_tap(0); send_tap(15); send_tap(30); send_tap(31); send_tap(255); send_tap(128);
        drain();
        set_filter(1, 1000, 8000);      // single tap, window is one
        send_tap(0); send_tap(1);
        drain();
        set_filter(0, 2000, 8000);      // no taps at all
        send_tap(0); send_tap(200);
        drain();
        set_filter(511, 131071, 0);     // tap count capped, rate zero, huge centre value
        send_tap(127); send_tap(128); send_tap(255); send_tap(0);
        drain();
        set_filter(2, 0, 262143);       // zero cutoff
        send_tap(0); send_tap(1); send_tap(2);
        drain();
        set_filter(256, 100000, 200000);
        send_tap(0); send_tap(127); send_tap(255);
        drain();

        // fixed and random settings; the long output hold fills the pipe
        for (int ph = 0; ph < 12; ph++) begin
            case (ph)
                0: set_filter(31, 1000, 8000);
                1: set_filter(256, 50000, 200000);
                2: set_filter(1, $urandom_range(0, 131071), $urandom_range(1, 262143));
                3: set_filter(2, 131071, 1);
                4: set_filter(300, $urandom_range(0, 100000), 0);
                default: set_filter($urandom_range(0, 511), $urandom_range(0, 131071),
                                    $urandom_range(0, 262143));
            endcase
            no_gaps = (ph % 4 == 3);
            if (ph == 1) begin
                no_gaps  = 1'b1;
                hold_req = 1'b1;
                random_taps(160);
            end else begin
                random_taps(45);
            end
            drain();
        end
        no_gaps = 1'b0;
        repeat (110) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending_taps.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
